### hw/rtl/abt_pkg.sv
`default_nettype none

package abt_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned RowW    = 3 * CoefW;
  localparam int unsigned ProdW   = CoefW + CoordW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned FracDrop = 12;
  localparam int unsigned RndW    = SumW - FracDrop;
  localparam int unsigned SqW     = 32;
  localparam int unsigned MinorW  = 2 * CoefW + 1;
  localparam int unsigned DetW    = CoefW + MinorW + 2;
  localparam int unsigned CfgIdxW = 3;

  // Column squared length limits in units of 2^-24 (0.999 and 1.001).
  localparam logic [SqW-1:0] SqLowLimit  = 32'd16760439;
  localparam logic [SqW-1:0] SqHighLimit = 32'd16793993;

  // Identity matrix in Q4.12 as reset values of the three rows.
  localparam logic [RowW-1:0] RowXReset = 48'h0000_0000_1000;
  localparam logic [RowW-1:0] RowYReset = 48'h0000_1000_0000;
  localparam logic [RowW-1:0] RowZReset = 48'h1000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_X   = 3'd0,
    CFG_ROW_Y   = 3'd1,
    CFG_ROW_Z   = 3'd2,
    CFG_SHIFT_X = 3'd3,
    CFG_SHIFT_Y = 3'd4,
    CFG_SHIFT_Z = 3'd5
  } cfg_idx_e;

  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [2:0][RowW-1:0]   rows;
    logic [2:0][CoordW-1:0] shifts;
  } abt_cfg_t;

  // Register enables of the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } abt_en_t;

  function automatic coef_t coef(input logic [RowW-1:0] row, input logic [1:0] col);
    coef_t c;
    c = coef_t'(row[CoefW*col +: CoefW]);
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/abt_if.sv
`default_nettype none

interface abt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lo_x;
  logic signed [31:0] lo_y;
  logic signed [31:0] lo_z;
  logic signed [31:0] hi_x;
  logic signed [31:0] hi_y;
  logic signed [31:0] hi_z;

  modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
  modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface abt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_lo_x;
  logic signed [31:0] out_lo_y;
  logic signed [31:0] out_lo_z;
  logic signed [31:0] out_hi_x;
  logic signed [31:0] out_hi_y;
  logic signed [31:0] out_hi_z;
  logic               has_scale;
  logic               flips_handedness;

  modport source (output valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y,
                  out_hi_z, has_scale, flips_handedness, input ready);
  modport sink   (input valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y,
                  out_hi_z, has_scale, flips_handedness, output ready);
endinterface

`default_nettype wire

### hw/rtl/abt_cfg_regs.sv
`default_nettype none

module abt_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [abt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [abt_pkg::RowW-1:0]     cfg_data_i,
  output abt_pkg::abt_cfg_t                 cfg_o
);
  import abt_pkg::*;

  abt_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows[0]   <= RowXReset;
      cfg_q.rows[1]   <= RowYReset;
      cfg_q.rows[2]   <= RowZReset;
      cfg_q.shifts[0] <= '0;
      cfg_q.shifts[1] <= '0;
      cfg_q.shifts[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_X:   cfg_q.rows[0]   <= cfg_data_i;
        CFG_ROW_Y:   cfg_q.rows[1]   <= cfg_data_i;
        CFG_ROW_Z:   cfg_q.rows[2]   <= cfg_data_i;
        CFG_SHIFT_X: cfg_q.shifts[0] <= cfg_data_i[CoordW-1:0];
        CFG_SHIFT_Y: cfg_q.shifts[1] <= cfg_data_i[CoordW-1:0];
        CFG_SHIFT_Z: cfg_q.shifts[2] <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/abt_row_lane.sv
`default_nettype none

// One output axis: products, min/max selection, two-level sum, rounding.
module abt_row_lane (
  input  wire logic                clk_i,
  input  wire abt_pkg::abt_en_t    en_i,
  input  wire abt_pkg::coef_t      coef_i [3],
  input  wire abt_pkg::coord_t     shift_i,
  input  wire abt_pkg::coord_t     lo_i [3],
  input  wire abt_pkg::coord_t     hi_i [3],
  output abt_pkg::coord_t          lo_o,
  output abt_pkg::coord_t          hi_o
);
  import abt_pkg::*;

  logic signed [ProdW-1:0] p_q  [3];
  logic signed [ProdW-1:0] q_q  [3];
  logic signed [ProdW-1:0] mn_q [3];
  logic signed [ProdW-1:0] mx_q [3];
  logic signed [SumW-1:0]  mn_a_q, mn_b_q, mx_a_q, mx_b_q;
  logic signed [SumW-1:0]  shift_ext;
  logic signed [SumW-1:0]  mn_sum, mx_sum;
  logic signed [RndW-1:0]  mn_rnd, mx_rnd;
  coord_t                  lo_q, hi_q;

  function automatic coord_t saturate(input logic signed [RndW-1:0] v);
    coord_t r;
    if ((&v[RndW-1:CoordW-1]) || !(|v[RndW-1:CoordW-1])) begin
      r = v[CoordW-1:0];
    end else if (v[RndW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  // Stage 1: six exact products in Q20.28.
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int c = 0; c < 3; c++) begin
        p_q[c] <= ProdW'(coef_i[c]) * ProdW'(lo_i[c]);
        q_q[c] <= ProdW'(coef_i[c]) * ProdW'(hi_i[c]);
      end
    end
  end

  // Stage 2: smaller and larger product of each input axis.
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int c = 0; c < 3; c++) begin
        mn_q[c] <= (p_q[c] < q_q[c]) ? p_q[c] : q_q[c];
        mx_q[c] <= (p_q[c] < q_q[c]) ? q_q[c] : p_q[c];
      end
    end
  end

  // Stage 3: partial sums, the translation rides in the first pair.
  assign shift_ext = SumW'(shift_i) <<< FracDrop;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      mn_a_q <= shift_ext + SumW'(mn_q[0]);
      mn_b_q <= SumW'(mn_q[1]) + SumW'(mn_q[2]);
      mx_a_q <= shift_ext + SumW'(mx_q[0]);
      mx_b_q <= SumW'(mx_q[1]) + SumW'(mx_q[2]);
    end
  end

  // Stage 4: final sum, round half up to Q16.16, saturate.
  assign mn_sum = mn_a_q + mn_b_q + SumW'(1 << (FracDrop - 1));
  assign mx_sum = mx_a_q + mx_b_q + SumW'(1 << (FracDrop - 1));
  assign mn_rnd = mn_sum[SumW-1:FracDrop];
  assign mx_rnd = mx_sum[SumW-1:FracDrop];

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      lo_q <= saturate(mn_rnd);
      hi_q <= saturate(mx_rnd);
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

`default_nettype wire

### hw/rtl/abt_flags.sv
`default_nettype none

// Scale and handedness flags of the 3x3 part, staged alongside the lanes.
module abt_flags (
  input  wire logic              clk_i,
  input  wire abt_pkg::abt_en_t  en_i,
  input  wire abt_pkg::coef_t    a_i [3][3],
  output logic                   has_scale_o,
  output logic                   flips_o
);
  import abt_pkg::*;

  logic [SqW-1:0]             sq_q    [3][3];
  logic signed [2*CoefW-1:0]  mprod_q [3][2];
  logic signed [MinorW-1:0]   minor_q [3];
  logic                       scale2_q, scale3_q, scale4_q;
  logic signed [DetW-1:0]     term_q  [3];
  logic signed [DetW-1:0]     det;
  logic                       flip_q;
  logic [SqW-1:0]             len     [3];
  logic                       scale_any;

  // Stage 1: squares of every coefficient and the 2x2 cofactor products.
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          sq_q[r][c] <= SqW'((2*CoefW)'(a_i[r][c]) * (2*CoefW)'(a_i[r][c]));
        end
      end
      mprod_q[0][0] <= (2*CoefW)'(a_i[1][1]) * (2*CoefW)'(a_i[2][2]);
      mprod_q[0][1] <= (2*CoefW)'(a_i[1][2]) * (2*CoefW)'(a_i[2][1]);
      mprod_q[1][0] <= (2*CoefW)'(a_i[1][0]) * (2*CoefW)'(a_i[2][2]);
      mprod_q[1][1] <= (2*CoefW)'(a_i[1][2]) * (2*CoefW)'(a_i[2][0]);
      mprod_q[2][0] <= (2*CoefW)'(a_i[1][0]) * (2*CoefW)'(a_i[2][1]);
      mprod_q[2][1] <= (2*CoefW)'(a_i[1][1]) * (2*CoefW)'(a_i[2][0]);
    end
  end

  // Stage 2: column lengths against the limits, cofactors.
  always_comb begin
    scale_any = 1'b0;
    for (int c = 0; c < 3; c++) begin
      len[c] = sq_q[0][c] + sq_q[1][c] + sq_q[2][c];
      if (len[c] < SqLowLimit || len[c] > SqHighLimit) begin
        scale_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      scale2_q <= scale_any;
      for (int k = 0; k < 3; k++) begin
        minor_q[k] <= MinorW'(mprod_q[k][0]) - MinorW'(mprod_q[k][1]);
      end
    end
  end

  // Stage 3: top row times cofactors.
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      scale3_q <= scale2_q;
      for (int k = 0; k < 3; k++) begin
        term_q[k] <= DetW'(a_i[0][k]) * DetW'(minor_q[k]);
      end
    end
  end

  // Stage 4: determinant sign.
  assign det = term_q[0] - term_q[1] + term_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      scale4_q <= scale3_q;
      flip_q   <= det[DetW-1];
    end
  end

  assign has_scale_o = scale4_q;
  assign flips_o     = flip_q;

endmodule

`default_nettype wire

### hw/rtl/affine_box_transform.sv
`default_nettype none

// Affine box transform. A 3x4 affine matrix, held in six configuration
// registers (three rows of packed Q4.12 coefficients and three Q16.16
// translations), maps each incoming axis-aligned box to the box that encloses
// its image. Coordinates are Q16.16; each output coordinate is rounded half up
// and saturated to 32 bits. Every result word also reports whether a column
// of the 3x3 part has a squared length outside [0.999, 1.001] and whether its
// determinant is negative. The datapath is a four-stage pipeline: products,
// min/max selection, partial sums, and final sum with rounding, the last stage
// being the output register. One word is accepted per cycle while the input is
// ready, and its result passes the stage registers in order; back-pressure
// stalls the pipeline in place, and empty stages are filled even while the
// output waits. Configuration must be written only while no word is in flight.
module affine_box_transform (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [abt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [abt_pkg::RowW-1:0]     cfg_data_i,
  abt_in_if.sink                            in_i,
  abt_out_if.source                         out_o
);
  import abt_pkg::*;

  abt_cfg_t cfg;
  abt_en_t  en;
  logic     v1_q, v2_q, v3_q, v4_q;
  coef_t    a [3][3];
  coord_t   lo [3];
  coord_t   hi [3];
  coord_t   lane_lo [3];
  coord_t   lane_hi [3];

  abt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // A stage may load when it is empty or when the stage after it moves on.
  // The last stage is the output register.
  assign en.s4 = !v4_q || out_o.ready;
  assign en.s3 = !v3_q || en.s4;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;

  assign in_i.ready = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_i.valid;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a[r][c] = coef(cfg.rows[r], 2'(c));
      end
    end
  end

  assign lo[0] = in_i.lo_x;
  assign lo[1] = in_i.lo_y;
  assign lo[2] = in_i.lo_z;
  assign hi[0] = in_i.hi_x;
  assign hi[1] = in_i.hi_y;
  assign hi[2] = in_i.hi_z;

  // One lane per output axis, all sharing the stage enables.
  for (genvar r = 0; r < 3; r++) begin : g_lane
    abt_row_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .coef_i  (a[r]),
      .shift_i (coord_t'(cfg.shifts[r])),
      .lo_i    (lo),
      .hi_i    (hi),
      .lo_o    (lane_lo[r]),
      .hi_o    (lane_hi[r])
    );
  end

  // The flags depend on the matrix only, but travel with each word so that
  // they leave the output register together with its coordinates.
  abt_flags u_flags (
    .clk_i       (clk_i),
    .en_i        (en),
    .a_i         (a),
    .has_scale_o (out_o.has_scale),
    .flips_o     (out_o.flips_handedness)
  );

  assign out_o.valid    = v4_q;
  assign out_o.out_lo_x = lane_lo[0];
  assign out_o.out_lo_y = lane_lo[1];
  assign out_o.out_lo_z = lane_lo[2];
  assign out_o.out_hi_x = lane_hi[0];
  assign out_o.out_hi_y = lane_hi[1];
  assign out_o.out_hi_z = lane_hi[2];

endmodule

`default_nettype wire

### tb/affine_box_transform_test.sv
module affine_box_transform_test;
  import abt_pkg::*;

  // Every word gets one result word, so a watchdog that sees no handshake on
  // either channel for this many cycles means the block has hung.
  localparam int StallLimit = 2000;
  // Length of the long output hold-off that fills the pipeline.
  localparam int HoldCycles = 300;
  // The pipeline is four stages deep; this margin covers it with room to spare.
  localparam int DrainCycles = 6;
  localparam int RandomPhases = 12;
  localparam int WordsPerPhase = 112;

  localparam coord_t MinCoord = 32'sh8000_0000;
  localparam coord_t MaxCoord = 32'sh7FFF_FFFF;
  localparam coord_t OneQ = 32'sh0001_0000;
  localparam coord_t MinusOneLsb = 32'shFFFF_FFFF;

  // Register indexes past the last register; writes there must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  localparam logic [CoefW-1:0] CoefUnit = 16'h1000;
  localparam logic [CoefW-1:0] CoefMax = 16'h7FFF;
  localparam logic [CoefW-1:0] CoefMin = 16'h8000;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  typedef struct packed {
    box_t bounds;
    logic has_scale;
    logic flips_handedness;
  } result_t;

  // One row of the directed table: either a register write or a box word,
  // the latter with an optional hand-written expectation.
  typedef struct {
    bit                  write;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [RowW-1:0]     reg_data;
    box_t                box;
    bit                  known;
    result_t             want;
  } plan_row_t;

  // Kinds of matrix that the random phases load.
  typedef enum int {
    StyleTurn,
    StyleNearUnit,
    StyleWild,
    StyleEdge,
    StyleModest
  } cfg_style_e;

  // Patterns of the output ready.
  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadySparse,
    ReadyPeriodic
  } ready_mode_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [RowW-1:0]     cfg_data;

  abt_in_if  in_if ();
  abt_out_if out_if ();

  affine_box_transform u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Our own copy of the six registers, updated on every write we issue.
  logic [RowW-1:0] mat_rows [3] = '{RowXReset, RowYReset, RowZReset};
  coord_t          mat_shift [3] = '{default: '0};

  result_t   pending_boxes [$];
  plan_row_t stimulus_plan [$];
  int        mismatch_count = 0;
  bit        hold_output = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Rounds a sum in Q20.28 to Q16.16, half toward plus infinity, and clamps it
  // to the 32-bit range.
  function automatic coord_t round_to_coord(input longint sum);
    longint r;
    r = (sum + 2048) >>> FracDrop;
    if (r > longint'(MaxCoord)) r = longint'(MaxCoord);
    if (r < longint'(MinCoord)) r = longint'(MinCoord);
    return coord_t'(r);
  endfunction

  // Maps one box through the current matrix. For each output axis the smaller
  // product of every input axis goes into the new minimum and the larger one
  // into the new maximum, which holds even when a corner is inverted.
  function automatic result_t transform_box(input box_t b);
    longint  a [3][3];
    longint  lo [3];
    longint  hi [3];
    coord_t  new_lo [3];
    coord_t  new_hi [3];
    longint  smin, smax, p, q, len, det;
    result_t r;
    int      row, col;
    lo[0] = longint'(b.lo_x);
    lo[1] = longint'(b.lo_y);
    lo[2] = longint'(b.lo_z);
    hi[0] = longint'(b.hi_x);
    hi[1] = longint'(b.hi_y);
    hi[2] = longint'(b.hi_z);
    for (row = 0; row < 3; row++) begin
      for (col = 0; col < 3; col++) begin
        a[row][col] = longint'(coef_t'(mat_rows[row][col*CoefW +: CoefW]));
      end
    end
    for (row = 0; row < 3; row++) begin
      smin = longint'(mat_shift[row]) * 4096;
      smax = smin;
      for (col = 0; col < 3; col++) begin
        p = a[row][col] * lo[col];
        q = a[row][col] * hi[col];
        if (p < q) begin
          smin += p;
          smax += q;
        end else begin
          smin += q;
          smax += p;
        end
      end
      new_lo[row] = round_to_coord(smin);
      new_hi[row] = round_to_coord(smax);
    end
    r.bounds.lo_x = new_lo[0];
    r.bounds.lo_y = new_lo[1];
    r.bounds.lo_z = new_lo[2];
    r.bounds.hi_x = new_hi[0];
    r.bounds.hi_y = new_hi[1];
    r.bounds.hi_z = new_hi[2];
    r.has_scale = 1'b0;
    for (col = 0; col < 3; col++) begin
      len = a[0][col] * a[0][col] + a[1][col] * a[1][col] + a[2][col] * a[2][col];
      if (len < longint'(SqLowLimit) || len > longint'(SqHighLimit)) r.has_scale = 1'b1;
    end
    det = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
        - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
        + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    r.flips_handedness = (det < 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic box_t mk_box(input coord_t lx, input coord_t ly, input coord_t lz,
                                  input coord_t hx, input coord_t hy, input coord_t hz);
    box_t b;
    b.lo_x = lx;
    b.lo_y = ly;
    b.lo_z = lz;
    b.hi_x = hx;
    b.hi_y = hy;
    b.hi_z = hz;
    return b;
  endfunction

  function automatic result_t mk_result(input box_t bnd, input bit scale, input bit flip);
    result_t r;
    r.bounds = bnd;
    r.has_scale = scale;
    r.flips_handedness = flip;
    return r;
  endfunction

  function automatic void plan_write(input logic [CfgIdxW-1:0] idx,
                                     input logic [RowW-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.write = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    stimulus_plan.push_back(row);
  endfunction

  function automatic void plan_box(input box_t b, input bit known, input result_t want);
    plan_row_t row;
    row = '{default: '0};
    row.box = b;
    row.known = known;
    row.want = want;
    stimulus_plan.push_back(row);
  endfunction

  // A coordinate of random magnitude: mostly a random word shifted down by a
  // random amount, now and then an extreme, zero or minus one LSB.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 15))
      0: return MinCoord;
      1: return MaxCoord;
      2: return '0;
      3: return MinusOneLsb;
      default: return coord_t'($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  // Most boxes are well formed; some are flat, inverted or unordered.
  function automatic box_t random_box();
    coord_t u [3];
    coord_t v [3];
    coord_t lo [3];
    coord_t hi [3];
    int     shape, k;
    shape = $urandom_range(0, 9);
    for (k = 0; k < 3; k++) begin
      u[k] = rand_coord();
      v[k] = rand_coord();
      if (shape <= 5) begin
        lo[k] = (u[k] < v[k]) ? u[k] : v[k];
        hi[k] = (u[k] < v[k]) ? v[k] : u[k];
      end else if (shape == 8) begin
        lo[k] = u[k];
        hi[k] = u[k];
      end else if (shape == 9) begin
        lo[k] = (u[k] < v[k]) ? v[k] : u[k];
        hi[k] = (u[k] < v[k]) ? u[k] : v[k];
      end else begin
        lo[k] = u[k];
        hi[k] = v[k];
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid is left
  // high so that the next word can follow without a bubble.
  task automatic push_box(input box_t b, input result_t want);
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.lo_x = b.lo_x;
    in_if.lo_y = b.lo_y;
    in_if.lo_z = b.lo_z;
    in_if.hi_x = b.hi_x;
    in_if.hi_y = b.hi_y;
    in_if.hi_z = b.hi_z;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_boxes.push_back(want);
  endtask

  // Drops valid for a number of cycles; the payload is scrambled meanwhile so
  // that the block is seen to ignore it.
  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_if.valid = 1'b0;
    in_if.lo_x = $urandom;
    in_if.lo_y = $urandom;
    in_if.lo_z = $urandom;
    in_if.hi_x = $urandom;
    in_if.hi_y = $urandom;
    in_if.hi_z = $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stops sending and waits until every result word is back, then lets the
  // pipeline run empty for a few more cycles.
  task automatic settle_pipeline();
    idle_input(1);
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_register(input logic [CfgIdxW-1:0] idx, input logic [RowW-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ROW_X:   mat_rows[0] = data;
      CFG_ROW_Y:   mat_rows[1] = data;
      CFG_ROW_Z:   mat_rows[2] = data;
      CFG_SHIFT_X: mat_shift[0] = data[CoordW-1:0];
      CFG_SHIFT_Y: mat_shift[1] = data[CoordW-1:0];
      CFG_SHIFT_Z: mat_shift[2] = data[CoordW-1:0];
      default: ;
    endcase
  endtask

  // Loads all six registers with a matrix of the given kind. Shift writes carry
  // random bits above the register width, and a write to an unused index is
  // thrown in each time.
  task automatic load_random_config(input cfg_style_e style);
    logic [RowW-1:0]  rows [3];
    logic [CoefW-1:0] v;
    coord_t           sh [3];
    int               perm [3];
    int               r, c, j, tmp;
    perm = '{0, 1, 2};
    for (r = 2; r > 0; r--) begin
      j = $urandom_range(0, r);
      tmp = perm[r];
      perm[r] = perm[j];
      perm[j] = tmp;
    end
    for (r = 0; r < 3; r++) begin
      rows[r] = '0;
      for (c = 0; c < 3; c++) begin
        case (style)
          // A signed permutation: unit columns, determinant of either sign.
          StyleTurn: v = (c == perm[r]) ? ($urandom_range(0, 1) ? CoefUnit : -CoefUnit) : '0;
          // Diagonal just inside and just outside the unit-length window.
          StyleNearUnit: begin
            v = (r == c) ? 16'($urandom_range(4092, 4100)) : 16'($urandom_range(0, 2));
            if ($urandom_range(0, 1)) v = -v;
          end
          StyleEdge: begin
            case ($urandom_range(0, 3))
              0: v = CoefMax;
              1: v = CoefMin;
              2: v = '0;
              default: v = CoefUnit;
            endcase
          end
          StyleModest: v = 16'($urandom_range(0, 16384) - 8192);
          default: v = 16'($urandom);
        endcase
        rows[r][c*CoefW +: CoefW] = v;
      end
      if (style == StyleEdge) begin
        case ($urandom_range(0, 2))
          0: sh[r] = MinCoord;
          1: sh[r] = MaxCoord;
          default: sh[r] = '0;
        endcase
      end else begin
        sh[r] = rand_coord();
      end
    end
    set_register(CFG_ROW_X, rows[0]);
    set_register(CFG_ROW_Y, rows[1]);
    set_register(CFG_ROW_Z, rows[2]);
    set_register(CFG_SHIFT_X, {16'($urandom), sh[0]});
    set_register(CFG_SHIFT_Y, {16'($urandom), sh[1]});
    set_register(CFG_SHIFT_Z, {16'($urandom), sh[2]});
    set_register($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, {16'($urandom), 32'($urandom)});
  endtask

  function automatic void check_field(input string field_name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, field_name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases.
  // ---------------------------------------------------------------------------
  initial begin
    box_t      b;
    result_t   want;
    plan_row_t row;
    int        phase, sent, burst, k;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.lo_x = '0;
    in_if.lo_y = '0;
    in_if.lo_z = '0;
    in_if.hi_x = '0;
    in_if.hi_y = '0;
    in_if.hi_z = '0;

    // After reset the matrix is the identity with no translation, so the first
    // few words come back as their own bounding box with both flags clear.
    b = mk_box(OneQ, 2 * OneQ, 3 * OneQ, 4 * OneQ, 5 * OneQ, 6 * OneQ);
    plan_box(b, 1'b1, mk_result(b, 1'b0, 1'b0));
    b = mk_box(MinCoord, MinCoord, MinCoord, MaxCoord, MaxCoord, MaxCoord);
    plan_box(b, 1'b1, mk_result(b, 1'b0, 1'b0));
    // Inverted corners are not reordered, but min and max are still taken.
    plan_box(mk_box(MaxCoord, MaxCoord, MaxCoord, MinCoord, MinCoord, MinCoord), 1'b1,
             mk_result(b, 1'b0, 1'b0));
    b = mk_box('0, '0, '0, '0, '0, '0);
    plan_box(b, 1'b1, mk_result(b, 1'b0, 1'b0));
    plan_box(mk_box(MinusOneLsb, 32'sd1, -OneQ, 32'sd1, MinusOneLsb, OneQ), 1'b1,
             mk_result(mk_box(MinusOneLsb, MinusOneLsb, -OneQ, 32'sd1, 32'sd1, OneQ),
                       1'b0, 1'b0));

    // A half on x makes odd coordinates land exactly between two steps, which
    // exercises the round-half-up rule on both signs.
    plan_write(CFG_ROW_X, 48'h0000_0000_0800);
    plan_box(mk_box(MinusOneLsb, '0, '0, 32'sd1, '0, '0), 1'b0, '0);
    plan_box(mk_box(-32'sd3, OneQ, OneQ, 32'sd3, OneQ, OneQ), 1'b0, '0);

    // Largest coefficients on y and a mirror on z; the shift writes carry bits
    // above the register width that must be dropped.
    plan_write(CFG_ROW_Y, {CoefMax, CoefMax, CoefMax});
    plan_write(CFG_SHIFT_Y, 48'hFFFF_7FFF_FFFF);
    plan_write(CFG_ROW_Z, {-CoefUnit, 16'h0000, 16'h0000});
    plan_write(CFG_SHIFT_Z, 48'hA5A5_8000_0000);
    plan_box(mk_box(MinCoord, MinCoord, MinCoord, MaxCoord, MaxCoord, MaxCoord), 1'b0, '0);
    plan_box(mk_box(MaxCoord, MaxCoord, MaxCoord, MaxCoord, MaxCoord, MaxCoord), 1'b0, '0);
    plan_box(mk_box(MinCoord, MinCoord, MinCoord, MinCoord, MinCoord, MinCoord), 1'b0, '0);
    plan_box(mk_box(OneQ, OneQ, OneQ, 2 * OneQ, 2 * OneQ, 2 * OneQ), 1'b0, '0);

    // Most negative coefficients, an all-zero row, and a full positive shift.
    plan_write(CFG_ROW_Y, {CoefMin, CoefMin, CoefMin});
    plan_write(CFG_ROW_X, 48'h0);
    plan_write(CFG_SHIFT_X, {16'h0000, MaxCoord});
    plan_box(mk_box(MinCoord, MinCoord, MinCoord, MaxCoord, MaxCoord, MaxCoord), 1'b0, '0);
    plan_box(mk_box(MaxCoord, MaxCoord, MaxCoord, MinCoord, MinCoord, MinCoord), 1'b0, '0);
    plan_box(mk_box(MinusOneLsb, MinusOneLsb, MinusOneLsb, '0, '0, '0), 1'b0, '0);

    // Writes to the unused indexes must leave every register alone.
    plan_write(CfgSpareA, '1);
    plan_write(CfgSpareB, '1);
    plan_box(mk_box(OneQ, OneQ, OneQ, 3 * OneQ, 3 * OneQ, 3 * OneQ), 1'b0, '0);
    plan_box(mk_box(32'sh1234_5678, -32'sh0765_4321, 32'sh00AB_CDEF,
                    32'sh2345_6789, 32'sh0FED_CBA9, -32'sh0000_1111), 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stimulus_plan[i]) begin
      row = stimulus_plan[i];
      if (row.write) begin
        settle_pipeline();
        set_register(row.reg_idx, row.reg_data);
      end else begin
        want = row.known ? row.want : transform_box(row.box);
        push_box(row.box, want);
        if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 3));
      end
    end

    // Random phases. Each starts from an empty pipeline, loads a fresh matrix
    // and streams words in bursts of random length with random gaps; a quarter
    // of the bursts are followed straight by the next. Draining between phases
    // is also the sender pause that lets every pending result come home.
    for (phase = 0; phase < RandomPhases; phase++) begin
      settle_pipeline();
      load_random_config(cfg_style_e'(phase % 5));
      // In one phase the receiver holds off for a long stretch while words
      // keep coming, so the pipeline fills up and back-pressures the input.
      if (phase == 4) hold_output = 1'b1;
      sent = 0;
      while (sent < WordsPerPhase) begin
        burst = $urandom_range(1, 40);
        for (k = 0; k < burst && sent < WordsPerPhase; k++) begin
          b = random_box();
          push_box(b, transform_box(b));
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 8));
      end
    end

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows one of several patterns, each held for a random
  // span, and drops for a long stretch when the main sequence asks for it.
  // ---------------------------------------------------------------------------
  initial begin
    ready_mode_e mode;
    int          span, tick;
    out_if.ready = 1'b0;
    mode = ReadyAlways;
    span = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_output = 1'b0;
      end else begin
        if (span == 0) begin
          mode = ready_mode_e'($urandom_range(0, 3));
          span = $urandom_range(16, 160);
        end
        span--;
        tick++;
        case (mode)
          ReadyAlways:  out_if.ready = 1'b1;
          ReadyCoin:    out_if.ready = $urandom_range(0, 1);
          ReadySparse:  out_if.ready = ($urandom_range(0, 3) == 0);
          default:      out_if.ready = (tick % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result word taken must match the oldest pending expectation.
  // ---------------------------------------------------------------------------
  initial begin
    result_t want, got;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.bounds.lo_x = out_if.out_lo_x;
        got.bounds.lo_y = out_if.out_lo_y;
        got.bounds.lo_z = out_if.out_lo_z;
        got.bounds.hi_x = out_if.out_hi_x;
        got.bounds.hi_y = out_if.out_hi_y;
        got.bounds.hi_z = out_if.out_hi_z;
        got.has_scale = out_if.has_scale;
        got.flips_handedness = out_if.flips_handedness;
        if (pending_boxes.size() == 0) begin
          $display("%0t: result word with nothing pending, expected none, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = pending_boxes.pop_front();
          check_field("out_lo_x", want.bounds.lo_x, got.bounds.lo_x);
          check_field("out_lo_y", want.bounds.lo_y, got.bounds.lo_y);
          check_field("out_lo_z", want.bounds.lo_z, got.bounds.lo_z);
          check_field("out_hi_x", want.bounds.hi_x, got.bounds.hi_x);
          check_field("out_hi_y", want.bounds.hi_y, got.bounds.hi_y);
          check_field("out_hi_z", want.bounds.hi_z, got.bounds.hi_z);
          check_field("has_scale", 32'(want.has_scale), 32'(got.has_scale));
          check_field("flips_handedness", 32'(want.flips_handedness),
                      32'(got.flips_handedness));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles without a handshake on either channel.
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles, %0d results pending", $time, quiet,
                 pending_boxes.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
